>>> rtl/gzhdr_pkg.sv
package gzhdr_pkg;

    localparam logic [7:0] DEFLATE_METHOD = 8'd8;
    localparam logic [7:0] FLAG_RESERVED  = 8'hE0;
    localparam logic [7:0] FLAG_EXTRA     = 8'h04;
    localparam logic [7:0] FLAG_NAME      = 8'h08;
    localparam logic [7:0] FLAG_COMMENT   = 8'h10;
    localparam logic [7:0] FLAG_HCRC      = 8'h02;

    // Fixed header bytes and the positions of the method and flags bytes.
    localparam logic [3:0] FIXED_LEN      = 4'd10;
    localparam logic [3:0] POS_METHOD     = 4'd2;
    localparam logic [3:0] POS_FLAGS      = 4'd3;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [7:0] {
        PH_FIXED   = 8'b0000_0001,
        PH_XLEN    = 8'b0000_0010,
        PH_XSKIP   = 8'b0000_0100,
        PH_NAME    = 8'b0000_1000,
        PH_COMMENT = 8'b0001_0000,
        PH_HCRC    = 8'b0010_0000,
        PH_DATA    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } t_phase;

    // Earliest optional field that the search may land on.
    typedef enum logic [1:0] {
        FROM_XLEN    = 2'd0,
        FROM_NAME    = 2'd1,
        FROM_COMMENT = 2'd2,
        FROM_HCRC    = 2'd3
    } t_from;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] byte_kind;
        logic       method_error;
        logic       reserved_warning;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  fixed_count;
        logic [7:0]  header_flags;
        logic [15:0] extra_remaining;
        logic        length_low_seen;
        logic        error_seen;
        logic        warning_seen;
    } t_state;

    localparam t_state STATE_INIT = '{
        phase:           PH_FIXED,
        fixed_count:     4'd0,
        header_flags:    8'd0,
        extra_remaining: 16'd0,
        length_low_seen: 1'b0,
        error_seen:      1'b0,
        warning_seen:    1'b0
    };

    // First optional field at or after 'from' whose flag is set, else data.
    function automatic t_phase f_next_stage(input t_from from, input logic [7:0] flags);
        t_phase ph;
        ph = PH_DATA;
        if ((flags & FLAG_HCRC) != 8'd0) begin
            ph = PH_HCRC;
        end
        if (from != FROM_HCRC && (flags & FLAG_COMMENT) != 8'd0) begin
            ph = PH_COMMENT;
        end
        if ((from == FROM_XLEN || from == FROM_NAME) && (flags & FLAG_NAME) != 8'd0) begin
            ph = PH_NAME;
        end
        if (from == FROM_XLEN && (flags & FLAG_EXTRA) != 8'd0) begin
            ph = PH_XLEN;
        end
        return ph;
    endfunction

endpackage

>>> rtl/gzhdr_if.sv
interface gzhdr_in_if import gzhdr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gzhdr_out_if import gzhdr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gzhdr_step.sv
module gzhdr_step import gzhdr_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_new_file,
    output t_state     o_state,
    output t_out_item  o_result
);

    t_state      cur;
    t_state      nxt;
    t_kind       kind;
    logic [15:0] extra_len;
    logic [15:0] extra_dec;

    always_comb begin
        cur       = i_new_file ? STATE_INIT : i_state;
        nxt       = cur;
        kind      = KIND_HEADER;
        extra_len = cur.extra_remaining | {i_data_byte, 8'd0};
        extra_dec = cur.extra_remaining - 16'd1;

        case (cur.phase)
            PH_FIXED: begin
                if (cur.fixed_count == POS_METHOD && i_data_byte != DEFLATE_METHOD) begin
                    nxt.error_seen = 1'b1;
                    nxt.phase      = PH_ERROR;
                    kind           = KIND_REJECT;
                end else begin
                    if (cur.fixed_count == POS_FLAGS) begin
                        nxt.header_flags = i_data_byte;
                        if ((i_data_byte & FLAG_RESERVED) != 8'd0) begin
                            nxt.warning_seen = 1'b1;
                        end
                    end
                    nxt.fixed_count = cur.fixed_count + 4'd1;
                    if (nxt.fixed_count >= FIXED_LEN) begin
                        nxt.phase = f_next_stage(FROM_XLEN, nxt.header_flags);
                    end
                end
            end
            PH_XLEN: begin
                if (!cur.length_low_seen) begin
                    nxt.extra_remaining = {8'd0, i_data_byte};
                    nxt.length_low_seen = 1'b1;
                end else begin
                    nxt.extra_remaining = extra_len;
                    nxt.length_low_seen = 1'b0;
                    nxt.phase = (extra_len != 16'd0) ? PH_XSKIP
                                : f_next_stage(FROM_NAME, cur.header_flags);
                end
            end
            PH_XSKIP: begin
                nxt.extra_remaining = extra_dec;
                if (extra_dec == 16'd0) begin
                    nxt.phase = f_next_stage(FROM_NAME, cur.header_flags);
                end
            end
            PH_NAME: begin
                if (i_data_byte == 8'd0) begin
                    nxt.phase = f_next_stage(FROM_COMMENT, cur.header_flags);
                end
            end
            PH_COMMENT: begin
                if (i_data_byte == 8'd0) begin
                    nxt.phase = f_next_stage(FROM_HCRC, cur.header_flags);
                end
            end
            PH_HCRC: begin
                if (!cur.length_low_seen) begin
                    nxt.length_low_seen = 1'b1;
                end else begin
                    nxt.length_low_seen = 1'b0;
                    nxt.phase           = PH_DATA;
                end
            end
            PH_DATA: begin
                kind = KIND_DATA;
            end
            default: begin
                kind = KIND_REJECT;
            end
        endcase

        o_state                   = nxt;
        o_result.payload_byte     = i_data_byte;
        o_result.byte_kind        = kind;
        o_result.method_error     = nxt.error_seen;
        o_result.reserved_warning = nxt.warning_seen;
    end

endmodule

>>> rtl/gzip_header_skip_parser_unit.sv
// Gzip member header skipper. Bytes of a gzip file enter on i_in, one per
// transfer, each with a new_file bit that restarts parsing at that byte.
// Every input byte yields exactly one result on o_out: the byte itself, its
// kind (header, compressed data, or rejected from a bad method byte on) and
// the sticky method error and reserved flag warning as they stand after it.
// The fixed header, the extra field, name, comment and header CRC are all
// tagged as header; everything after them is tagged as data.
// The result of a byte is registered and offered in the cycle after the byte
// is accepted. Throughput is one byte per cycle while o_out is not stalled,
// set by the single parser state register, updated as each byte is accepted.
// The result register frees up in the same cycle in which its contents are
// taken, so a new byte is accepted whenever o_out is empty or being read.
// When the receiver stalls, the result is held and i_in.ready drops until
// it is taken; no byte is lost or repeated.
// Reset empties the result register and returns the parser to the first
// fixed header byte with both sticky flags clear.
module gzip_header_skip_parser_unit import gzhdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gzhdr_in_if.sink          i_in,
    gzhdr_out_if.source       o_out
);

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_fire;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    gzhdr_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_in.data.data_byte),
        .i_new_file  (i_in.data.new_file),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_INIT;
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gzhdr_pkg::*;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_vector;

    logic clk;
    logic rst_n;
    logic steady;

    gzhdr_in_if  in_bus ();
    gzhdr_out_if out_bus ();

    gzip_header_skip_parser_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Parser state as the testbench tracks it.
    t_phase      hdr_phase;
    logic [3:0]  fixed_seen;
    logic [7:0]  hdr_flags;
    logic [15:0] extra_left;
    logic        half_seen;
    logic        err_seen;
    logic        warn_seen;

    t_out_item tags_due[$];
    t_vector   directed_rows[$];
    int        bytes_sent;
    int        mismatch_count;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_parser();
        hdr_phase  = PH_FIXED;
        fixed_seen = 4'd0;
        hdr_flags  = 8'd0;
        extra_left = 16'd0;
        half_seen  = 1'b0;
        err_seen   = 1'b0;
        warn_seen  = 1'b0;
    endfunction

    // Optional header fields come in a fixed order; land on the first one
    // at or after the given point whose flag is set.
    function automatic t_phase field_after(input t_from from);
        if (from <= FROM_XLEN && (hdr_flags & FLAG_EXTRA) != 8'd0) return PH_XLEN;
        if (from <= FROM_NAME && (hdr_flags & FLAG_NAME) != 8'd0) return PH_NAME;
        if (from <= FROM_COMMENT && (hdr_flags & FLAG_COMMENT) != 8'd0) return PH_COMMENT;
        if ((hdr_flags & FLAG_HCRC) != 8'd0) return PH_HCRC;
        return PH_DATA;
    endfunction

    function automatic t_out_item tag_byte(input t_in_item it);
        t_out_item r;
        logic [7:0] b;
        b = it.data_byte;
        r.payload_byte = b;
        r.byte_kind = KIND_HEADER;
        if (it.new_file) begin
            clear_parser();
        end
        case (hdr_phase)
            PH_FIXED: begin
                if (fixed_seen == POS_METHOD && b != DEFLATE_METHOD) begin
                    err_seen = 1'b1;
                    hdr_phase = PH_ERROR;
                    r.byte_kind = KIND_REJECT;
                end else begin
                    if (fixed_seen == POS_FLAGS) begin
                        hdr_flags = b;
                        if ((b & FLAG_RESERVED) != 8'd0) warn_seen = 1'b1;
                    end
                    fixed_seen = fixed_seen + 4'd1;
                    if (fixed_seen >= FIXED_LEN) hdr_phase = field_after(FROM_XLEN);
                end
            end
            PH_XLEN: begin
                if (!half_seen) begin
                    extra_left = {8'd0, b};
                    half_seen = 1'b1;
                end else begin
                    extra_left = {b, extra_left[7:0]};
                    half_seen = 1'b0;
                    hdr_phase = (extra_left != 16'd0) ? PH_XSKIP : field_after(FROM_NAME);
                end
            end
            PH_XSKIP: begin
                extra_left = extra_left - 16'd1;
                if (extra_left == 16'd0) hdr_phase = field_after(FROM_NAME);
            end
            PH_NAME: begin
                if (b == 8'd0) hdr_phase = field_after(FROM_COMMENT);
            end
            PH_COMMENT: begin
                if (b == 8'd0) hdr_phase = field_after(FROM_HCRC);
            end
            PH_HCRC: begin
                if (!half_seen) begin
                    half_seen = 1'b1;
                end else begin
                    half_seen = 1'b0;
                    hdr_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                r.byte_kind = KIND_DATA;
            end
            default: begin
                r.byte_kind = KIND_REJECT;
            end
        endcase
        r.method_error = err_seen;
        r.reserved_warning = warn_seen;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic nf, input logic typed,
                                    input t_kind k, input logic e, input logic w);
        t_vector v;
        v.stim.data_byte = b;
        v.stim.new_file = nf;
        v.typed = typed;
        v.want.payload_byte = b;
        v.want.byte_kind = k;
        v.want.method_error = e;
        v.want.reserved_warning = w;
        directed_rows.push_back(v);
    endfunction

    // The valid line is only lowered while idling, so back-to-back transfers
    // never see it dropped and raised in one step.
    task automatic send_byte(input t_in_item it, input logic typed = 1'b0,
                             input t_out_item want = '0);
        t_out_item guess;
        while (!steady && $urandom_range(0, 99) < 17) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        guess = tag_byte(it);
        tags_due.push_back(typed ? want : guess);
        in_bus.valid <= 1'b1;
        in_bus.data <= it;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (tags_due.size() != 0);
    endtask

    task automatic send_member(input logic huge_extra);
        logic [7:0]  body[$];
        logic [7:0]  flags_byte;
        logic [15:0] xlen;
        int          pick;
        int          stop;
        t_in_item    it;
        flags_byte = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) flags_byte = flags_byte & ~FLAG_RESERVED;
        if (huge_extra) flags_byte = flags_byte | FLAG_EXTRA;
        body.push_back(8'h1F);
        body.push_back(8'h8B);
        if (!huge_extra && $urandom_range(0, 9) == 0) begin
            body.push_back(8'($urandom_range(0, 255)));
        end else begin
            body.push_back(DEFLATE_METHOD);
        end
        body.push_back(flags_byte);
        repeat (6) body.push_back(8'($urandom_range(0, 255)));
        if ((flags_byte & FLAG_EXTRA) != 8'd0) begin
            pick = $urandom_range(0, 9);
            if (huge_extra) begin
                xlen = 16'hFFFF;
            end else if (pick < 3) begin
                xlen = 16'd0;
            end else if (pick < 9) begin
                xlen = 16'($urandom_range(1, 8));
            end else begin
                xlen = 16'($urandom_range(200, 600));
            end
            body.push_back(xlen[7:0]);
            body.push_back(xlen[15:8]);
            repeat (xlen) body.push_back(8'($urandom_range(0, 255)));
        end
        if ((flags_byte & FLAG_NAME) != 8'd0) begin
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'd0);
        end
        if ((flags_byte & FLAG_COMMENT) != 8'd0) begin
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'd0);
        end
        if ((flags_byte & FLAG_HCRC) != 8'd0) begin
            repeat (2) body.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
        // Now and then a member is cut short; the next member usually restarts parsing.
        stop = body.size();
        if (!huge_extra && $urandom_range(0, 11) == 0) stop = $urandom_range(1, body.size());
        // The longest extra field is only followed for the first 112 to 312 bytes.
        if (huge_extra) stop = 12 + $urandom_range(100, 300);
        for (int i = 0; i < stop; i++) begin
            it.data_byte = body[i];
            it.new_file = (i == 0) && (huge_extra || $urandom_range(0, 15) != 0);
            send_byte(it);
        end
    endtask

    always @(posedge clk) begin
        t_out_item got;
        t_out_item want_now;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            got = out_bus.data;
            if (tags_due.size() == 0) begin
                $display("%0t: result with nothing expected: byte %h kind %0d err %b warn %b",
                         $realtime, got.payload_byte, got.byte_kind, got.method_error,
                         got.reserved_warning);
                mismatch_count++;
            end else begin
                want_now = tags_due.pop_front();
                if (got.payload_byte !== want_now.payload_byte
                        || got.byte_kind !== want_now.byte_kind
                        || got.method_error !== want_now.method_error
                        || got.reserved_warning !== want_now.reserved_warning) begin
                    $display("%0t: expected byte %h kind %0d err %b warn %b, got %h %0d %b %b",
                             $realtime, want_now.payload_byte, want_now.byte_kind,
                             want_now.method_error, want_now.reserved_warning,
                             got.payload_byte, got.byte_kind, got.method_error,
                             got.reserved_warning);
                    mismatch_count++;
                end
            end
        end
        out_bus.ready <= steady || ($urandom_range(0, 99) >= 17);
    end

    initial begin
        t_in_item it;
        clk = 1'b0;
        rst_n <= 1'b0;
        steady <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.data <= '0;
        bytes_sent = 0;
        mismatch_count = 0;
        clear_parser();

        // First bytes after reset with no restart, then a bad method byte.
        add_row(8'h1F, 1'b0, 1'b1, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h8B, 1'b0, 1'b1, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, KIND_REJECT, 1'b1, 1'b0);
        add_row(8'hFF, 1'b0, 1'b1, KIND_REJECT, 1'b1, 1'b0);
        // Restart clears the error; all flag bits set, zero extra length.
        add_row(8'h1F, 1'b1, 1'b1, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h8B, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h08, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b1, KIND_HEADER, 1'b0, 1'b1);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h41, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h55, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'hAA, 1'b0, 1'b0, KIND_HEADER, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_DATA, 1'b0, 1'b1);
        add_row(8'hFF, 1'b0, 1'b0, KIND_DATA, 1'b0, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_results();

        while (bytes_sent < 1550) begin
            steady <= (bytes_sent >= 600 && bytes_sent < 900);
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 20)) begin
                    it.data_byte = 8'($urandom_range(0, 255));
                    it.new_file = ($urandom_range(0, 7) == 0);
                    send_byte(it);
                end
            end else begin
                send_member(1'b0);
            end
        end
        steady <= 1'b0;

        // One member with the largest extra length, followed partway through.
        drain_results();
        send_member(1'b1);

        drain_results();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("gzip_header_skip_parser_unit verification clean");
        end else begin
            $display("gzip_header_skip_parser_unit verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("gzip_header_skip_parser_unit verification failed");
        $finish;
    end

endmodule
